// ----- rtl/utes_pkg.sv -----
// ----------------------------------------------------------------------------
// utes_pkg
// Shared types, constants and small tables for the UTC timestamp converter.
// ----------------------------------------------------------------------------
package utes_pkg;

	localparam int YEAR_W    = 14;
	localparam int FIELD_W   = 7;
	localparam int POS_W     = 5;
	localparam int SECS_W    = 38;
	localparam int CFG_IDX_W = 2;
	localparam int ERA_W     = 6;
	localparam int ERA_SHIFT = 22;

	localparam logic [POS_W-1:0] POS_LAST = 5'd19;
	localparam logic [POS_W-1:0] POS_LEN  = 5'd20;
	localparam logic [POS_W-1:0] POS_MAX  = 5'd31;

	localparam logic [CFG_IDX_W-1:0] CFG_EARLIEST_YEAR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LATEST_YEAR   = 2'd1;

	localparam logic [YEAR_W-1:0] EARLIEST_RST = 14'd2020;
	localparam logic [YEAR_W-1:0] LATEST_RST   = 14'd2200;
	localparam logic [YEAR_W-1:0] EPOCH_YEAR   = 14'd1970;

	// y / 400 == (y * ERA_RECIP) >> ERA_SHIFT for every 14-bit y
	localparam logic [YEAR_W-1:0] ERA_RECIP      = 14'd10486;
	localparam logic [YEAR_W-1:0] YEARS_PER_ERA  = 14'd400;
	localparam int                DAYS_PER_ERA   = 146097;
	localparam int                EPOCH_DAY_OFS  = 719468;
	localparam int                SECS_PER_DAY   = 86400;

	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	typedef struct packed {
		logic [7:0] character;
		logic       final_char;
	} in_item_t;

	typedef struct packed {
		logic              valid_res;
		logic [SECS_W-1:0] epoch_seconds;
	} out_item_t;

	// one parsed string handed from the parser to the converter
	typedef struct packed {
		logic               fmt_ok;
		logic [YEAR_W-1:0]  year;
		logic [FIELD_W-1:0] month;
		logic [FIELD_W-1:0] day;
		logic [FIELD_W-1:0] hour;
		logic [FIELD_W-1:0] minute;
		logic [FIELD_W-1:0] second;
	} fields_t;

	typedef struct packed {
		logic [YEAR_W-1:0] earliest;
		logic [YEAR_W-1:0] latest;
	} limits_t;

	// first day of each month in a March-based year
	function automatic logic [8:0] doy_base(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] month_len(input logic [FIELD_W-1:0] m);
		logic [4:0] r;
		case (m)
			7'd2:                      r = 5'd28;
			7'd4, 7'd6, 7'd9, 7'd11:   r = 5'd30;
			default:                   r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/utes_front.sv -----
// ----------------------------------------------------------------------------
// utes_front
// Character parser: checks each byte against its position and gathers fields.
// ----------------------------------------------------------------------------
module utes_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  utes_pkg::in_item_t in_data,
	input  logic               full,
	output logic               push,
	output utes_pkg::fields_t  push_data
);

	logic [utes_pkg::POS_W-1:0]   pos_q;
	logic                         err_q;
	logic [utes_pkg::YEAR_W-1:0]  year_q;
	logic [utes_pkg::FIELD_W-1:0] month_q, day_q, hour_q, minute_q, second_q;

	logic                         err_n;
	logic [utes_pkg::YEAR_W-1:0]  year_n;
	logic [utes_pkg::FIELD_W-1:0] month_n, day_n, hour_n, minute_n, second_n;
	logic                         digit;
	logic [3:0]                   dv;
	logic                         accept;

	function automatic logic [utes_pkg::FIELD_W-1:0] shift7(
		input logic [utes_pkg::FIELD_W-1:0] acc,
		input logic [3:0]                   d,
		input logic                         first
	);
		return first ? utes_pkg::FIELD_W'(d)
		             : utes_pkg::FIELD_W'({acc, 3'b000} + {acc, 1'b0} + utes_pkg::FIELD_W'(d));
	endfunction

	assign in_stall = full;
	assign accept   = in_valid && !full;
	assign digit    = (in_data.character >= utes_pkg::CH_0) &&
	                  (in_data.character <= utes_pkg::CH_9);
	assign dv       = digit ? 4'(in_data.character - utes_pkg::CH_0) : 4'd0;

	always_comb begin
		err_n    = err_q;
		year_n   = year_q;
		month_n  = month_q;
		day_n    = day_q;
		hour_n   = hour_q;
		minute_n = minute_q;
		second_n = second_q;
		case (pos_q)
			5'd4, 5'd7: begin
				if (in_data.character != utes_pkg::CH_DASH) err_n = 1'b1;
			end
			5'd10: begin
				if (in_data.character != utes_pkg::CH_T) err_n = 1'b1;
			end
			5'd13, 5'd16: begin
				if (in_data.character != utes_pkg::CH_COLON) err_n = 1'b1;
			end
			5'd19: begin
				if (in_data.character != utes_pkg::CH_Z) err_n = 1'b1;
			end
			default: begin
				if (pos_q >= utes_pkg::POS_LEN || !digit) begin
					err_n = 1'b1;
				end else if (pos_q <= 5'd3) begin
					year_n = (pos_q == 5'd0) ? utes_pkg::YEAR_W'(dv)
					       : utes_pkg::YEAR_W'({year_q, 3'b000} + {year_q, 1'b0}
					                           + utes_pkg::YEAR_W'(dv));
				end else if (pos_q <= 5'd6) begin
					month_n = shift7(month_q, dv, pos_q == 5'd5);
				end else if (pos_q <= 5'd9) begin
					day_n = shift7(day_q, dv, pos_q == 5'd8);
				end else if (pos_q <= 5'd12) begin
					hour_n = shift7(hour_q, dv, pos_q == 5'd11);
				end else if (pos_q <= 5'd15) begin
					minute_n = shift7(minute_q, dv, pos_q == 5'd14);
				end else begin
					second_n = shift7(second_q, dv, pos_q == 5'd17);
				end
			end
		endcase
	end

	assign push             = accept && in_data.final_char;
	assign push_data.fmt_ok = !err_n && (pos_q == utes_pkg::POS_LAST);
	assign push_data.year   = year_n;
	assign push_data.month  = month_n;
	assign push_data.day    = day_n;
	assign push_data.hour   = hour_n;
	assign push_data.minute = minute_n;
	assign push_data.second = second_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			err_q    <= 1'b0;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
		end else if (accept) begin
			if (in_data.final_char) begin
				// start a new string
				pos_q    <= '0;
				err_q    <= 1'b0;
				year_q   <= '0;
				month_q  <= '0;
				day_q    <= '0;
				hour_q   <= '0;
				minute_q <= '0;
				second_q <= '0;
			end else begin
				if (pos_q != utes_pkg::POS_MAX) pos_q <= pos_q + 5'd1;
				err_q    <= err_n;
				year_q   <= year_n;
				month_q  <= month_n;
				day_q    <= day_n;
				hour_q   <= hour_n;
				minute_q <= minute_n;
				second_q <= second_n;
			end
		end
	end

endmodule

// ----- rtl/utes_fifo.sv -----
// ----------------------------------------------------------------------------
// utes_fifo
// Small register queue between the parser and the converter.
// ----------------------------------------------------------------------------
module utes_fifo #(
	parameter int WIDTH = 50,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + AW'(1);
			if (pop)  rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + AW'(1);
			if (push && !pop)      count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue pop while empty");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("queue count did not advance on push");

endmodule

// ----- rtl/utes_back.sv -----
// ----------------------------------------------------------------------------
// utes_back
// Converter: range checks, date to Unix secs, one step a cycle unless stalled.
// ----------------------------------------------------------------------------
module utes_back (
	input  logic                clk,
	input  logic                arst_n,
	input  utes_pkg::limits_t   limits,
	input  logic                empty,
	input  utes_pkg::fields_t   rd_data,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output utes_pkg::out_item_t out_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_REM  = 3'd2;
	localparam logic [2:0] ST_DOE  = 3'd3;
	localparam logic [2:0] ST_DAYS = 3'd4;
	localparam logic [2:0] ST_SECS = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	localparam int DAYS_W = 23;
	localparam int DOE_W  = 18;
	localparam int HMS_W  = 17;

	logic [2:0]                      state_q;
	utes_pkg::fields_t               rec_q;
	logic [utes_pkg::YEAR_W-1:0]     yy_q;
	logic [utes_pkg::ERA_W-1:0]      era_y_q, era_yy_q;
	logic [8:0]                      doy_q, r400_q, yoe_q;
	logic [HMS_W-1:0]                hms_q;
	logic                            rng_ok_q, ok_q;
	logic [DOE_W-1:0]                doe_q;
	logic [DAYS_W-1:0]               days_q;
	logic [utes_pkg::SECS_W-1:0]     secs_q;
	logic                            out_valid_q;
	utes_pkg::out_item_t             out_data_q;

	logic                            mle2;
	logic [utes_pkg::YEAR_W-1:0]     yy_a;
	logic [27:0]                     prod_y, prod_yy;
	logic [utes_pkg::FIELD_W-1:0]    mp;
	logic                            rng_ok_a;
	logic [8:0]                      r100, cent_base;
	logic [1:0]                      cent;
	logic                            leap;
	logic [4:0]                      lim;
	logic                            out_free;

	assign pop      = (state_q == ST_IDLE) && !empty;
	assign out_free = !out_valid_q || !out_stall;

	// split off January and February into the previous counting year
	assign mle2    = (rec_q.month <= 7'd2);
	assign yy_a    = rec_q.year - utes_pkg::YEAR_W'(mle2);
	assign prod_y  = 28'(rec_q.year) * 28'(utes_pkg::ERA_RECIP);
	assign prod_yy = 28'(yy_a) * 28'(utes_pkg::ERA_RECIP);
	assign mp      = mle2 ? rec_q.month + 7'd9 : rec_q.month - 7'd3;

	assign rng_ok_a = rec_q.fmt_ok
		&& (rec_q.year >= utes_pkg::EPOCH_YEAR)
		&& (rec_q.year >= limits.earliest) && (rec_q.year <= limits.latest)
		&& (rec_q.month >= 7'd1) && (rec_q.month <= 7'd12)
		&& (rec_q.day >= 7'd1)
		&& (rec_q.hour <= 7'd23) && (rec_q.minute <= 7'd59) && (rec_q.second <= 7'd59);

	// century within the era, from compares on the small remainders
	always_comb begin
		if (r400_q >= 9'd300)      cent_base = 9'd300;
		else if (r400_q >= 9'd200) cent_base = 9'd200;
		else if (r400_q >= 9'd100) cent_base = 9'd100;
		else                       cent_base = 9'd0;
		if (yoe_q >= 9'd300)      cent = 2'd3;
		else if (yoe_q >= 9'd200) cent = 2'd2;
		else if (yoe_q >= 9'd100) cent = 2'd1;
		else                      cent = 2'd0;
	end

	assign r100 = r400_q - cent_base;
	assign leap = (rec_q.year[1:0] == 2'b00) && ((r100 != 9'd0) || (r400_q == 9'd0));
	assign lim  = utes_pkg::month_len(rec_q.month)
	            + 5'((rec_q.month == 7'd2) && leap);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) rec_q <= rd_data;
			end
			ST_DIV: begin
				yy_q     <= yy_a;
				era_y_q  <= utes_pkg::ERA_W'(prod_y >> utes_pkg::ERA_SHIFT);
				era_yy_q <= utes_pkg::ERA_W'(prod_yy >> utes_pkg::ERA_SHIFT);
				doy_q    <= utes_pkg::doy_base(mp[3:0]) + 9'(rec_q.day) - 9'd1;
				rng_ok_q <= rng_ok_a;
			end
			ST_REM: begin
				r400_q <= 9'(rec_q.year
				         - utes_pkg::YEAR_W'(era_y_q) * utes_pkg::YEARS_PER_ERA);
				yoe_q  <= 9'(yy_q - utes_pkg::YEAR_W'(era_yy_q) * utes_pkg::YEARS_PER_ERA);
				hms_q  <= HMS_W'(rec_q.hour) * HMS_W'(3600)
				        + HMS_W'(rec_q.minute) * HMS_W'(60) + HMS_W'(rec_q.second);
			end
			ST_DOE: begin
				doe_q <= DOE_W'(yoe_q) * DOE_W'(365) + DOE_W'(yoe_q >> 2)
				       - DOE_W'(cent) + DOE_W'(doy_q);
				ok_q  <= rng_ok_q && (rec_q.day <= 7'(lim));
			end
			ST_DAYS: begin
				days_q <= DAYS_W'(era_yy_q) * DAYS_W'(utes_pkg::DAYS_PER_ERA)
				        + DAYS_W'(doe_q) - DAYS_W'(utes_pkg::EPOCH_DAY_OFS);
			end
			ST_SECS: begin
				secs_q <= utes_pkg::SECS_W'(days_q) * utes_pkg::SECS_W'(utes_pkg::SECS_PER_DAY)
				        + utes_pkg::SECS_W'(hms_q);
			end
			default: begin
			end
		endcase
		if (state_q == ST_OUT && out_free) begin
			out_data_q.valid_res     <= ok_q;
			out_data_q.epoch_seconds <= ok_q ? secs_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
			else if (!out_stall)                out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop) state_q <= ST_DIV;
				end
				ST_DIV:  state_q <= ST_REM;
				ST_REM:  state_q <= ST_DOE;
				ST_DOE:  state_q <= ST_DAYS;
				ST_DAYS: state_q <= ST_SECS;
				ST_SECS: state_q <= ST_OUT;
				ST_OUT: begin
					// hold until the output register is free
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == ST_DIV)) else $error("pop did not start a conversion");
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_data_q.valid_res) |-> (out_data_q.epoch_seconds == '0))
		else $error("invalid result carries nonzero seconds");
	a_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished conversion not delivered");

endmodule

// ----- rtl/utc_timestamp_to_epoch_seconds.sv -----
// ----------------------------------------------------------------------------
// utc_timestamp_to_epoch_seconds
// Parses YYYY-MM-DDTHH:MM:SSZ one character at a time and returns Unix seconds.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  in_data  : character, final_char
//  out      out_valid / out_stall out_data : valid_res, epoch_seconds
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data (earliest/latest year)
//
//  One character is taken per cycle; the parser never waits on the converter
//  until QUEUE_DEPTH parsed strings are pending.
//  The converter sequencer loads a string in IDLE, steps through DIV, REM,
//  DOE, DAYS and SECS, then delivers in OUT, holding there while stalled.
//  in_stall is high only while the queue between parser and converter is full.
//  Reset clears parse state, queue, sequencer and output valid; year limits
//  return to 2020 and 2200.
// ----------------------------------------------------------------------------
module utc_timestamp_to_epoch_seconds #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  utes_pkg::in_item_t               in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output utes_pkg::out_item_t              out_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [utes_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [utes_pkg::YEAR_W-1:0]      cfg_data
);

	localparam int REC_W = $bits(utes_pkg::fields_t);

	utes_pkg::limits_t limits_q;
	utes_pkg::fields_t push_data, rd_data;
	logic              push, pop, full, empty;
	logic [REC_W-1:0]  rd_bits;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.earliest <= utes_pkg::EARLIEST_RST;
			limits_q.latest   <= utes_pkg::LATEST_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				utes_pkg::CFG_EARLIEST_YEAR: limits_q.earliest <= cfg_data;
				utes_pkg::CFG_LATEST_YEAR:   limits_q.latest   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	utes_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	utes_fifo #(
		.WIDTH (REC_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_data),
		.pop     (pop),
		.rd_data (rd_bits),
		.full    (full),
		.empty   (empty)
	);

	assign rd_data = utes_pkg::fields_t'(rd_bits);

	utes_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.limits    (limits_q),
		.empty     (empty),
		.rd_data   (rd_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
